// ----- rtl/rbac_pkg.sv -----
// ----------------------------------------------------------------------------
// rbac_pkg
// Shared types and constants for the running baseline anomaly check.
// ----------------------------------------------------------------------------
package rbac_pkg;

  // operation codes carried in the input tuser
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_CHECK = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // configuration register indexes
  localparam logic [1:0] CFG_BASELINE_ON = 2'd0;
  localparam logic [1:0] CFG_MIN_SAMPLES = 2'd1;
  localparam logic [1:0] CFG_Z_GAIN      = 2'd2;

  // field widths
  localparam int unsigned DataW   = 32;
  localparam int unsigned GuardW  = 16;
  localparam int unsigned MeanW   = DataW + GuardW;
  localparam int unsigned M2W     = 64;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned OutCntW = 16;
  localparam int unsigned StdW    = 31;
  localparam int unsigned InDataW = 72;
  localparam int unsigned OutDataW = 120;

  // default parameter values
  localparam int unsigned CountBitsDef = 16;

  // iterative unit width and step counts
  localparam int unsigned OpW     = 64;
  localparam logic [6:0]  StepsW  = 7'd64;
  localparam logic [6:0]  StepsSq = 7'd32;

  // iterative unit mode
  typedef enum logic [1:0] {
    MODE_DIV  = 2'd0,
    MODE_SQRT = 2'd1,
    MODE_MUL  = 2'd2
  } mode_e;

  // request from sequencer to the iterative unit
  typedef struct packed {
    logic  start;
    mode_e mode;
  } iter_req_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_DIV,
    ST_ADD_MUL,
    ST_CHK_DIV,
    ST_CHK_SQRT,
    ST_CHK_MUL,
    ST_CHK_FIN
  } state_e;

endpackage

// ----- rtl/rbac_iter.sv -----
// ----------------------------------------------------------------------------
// rbac_iter
// Shared iterative unit: restoring divide, bitwise square root and
// shift-add multiply, one bit per cycle; div and sqrt share one subtractor.
// ----------------------------------------------------------------------------
module rbac_iter
  import rbac_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  iter_req_t           req_i,
  input  logic [OpW-1:0]      opa_i,
  input  logic [OpW-1:0]      opb_i,
  output logic                done_o,
  output logic [2*OpW-1:0]    res_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [6:0]        cnt_q, cnt_d;
  mode_e             mode_q, mode_d;
  logic [OpW+1:0]    rem_q, rem_d;
  logic [2*OpW-1:0]  res_q, res_d;
  logic [OpW-1:0]    src_q, src_d;
  logic [OpW-1:0]    opb_q, opb_d;

  logic [OpW+1:0]    trial_a;
  logic [OpW+1:0]    trial_b;
  logic [OpW+2:0]    diff;
  logic              ge;
  logic [2*OpW-1:0]  mac;

  // shared compare and subtract
  always_comb begin
    if (mode_q == MODE_DIV) begin
      trial_a = {rem_q[OpW:0], src_q[OpW-1]};
      trial_b = {2'b00, opb_q};
    end else begin
      trial_a = {rem_q[OpW-1:0], src_q[OpW-1:OpW-2]};
      trial_b = {res_q[OpW-1:0], 2'b01};
    end
    diff = {1'b0, trial_a} - {1'b0, trial_b};
    ge   = ~diff[OpW+2];
    mac  = {res_q[2*OpW-2:0], 1'b0} + (src_q[OpW-1] ? {{OpW{1'b0}}, opb_q} : '0);
  end

  // step control
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    mode_d = mode_q;
    rem_d  = rem_q;
    res_d  = res_q;
    src_d  = src_q;
    opb_d  = opb_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      mode_d = req_i.mode;
      cnt_d  = (req_i.mode == MODE_SQRT) ? StepsSq : StepsW;
      rem_d  = '0;
      res_d  = '0;
      src_d  = opa_i;
      opb_d  = opb_i;
    end else if (busy_q) begin
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
      case (mode_q)
        MODE_DIV: begin
          rem_d = ge ? diff[OpW+1:0] : trial_a;
          res_d = {res_q[2*OpW-2:0], ge};
          src_d = {src_q[OpW-2:0], 1'b0};
        end
        MODE_SQRT: begin
          rem_d = ge ? diff[OpW+1:0] : trial_a;
          res_d = {res_q[2*OpW-2:0], ge};
          src_d = {src_q[OpW-3:0], 2'b00};
        end
        MODE_MUL: begin
          res_d = mac;
          src_d = {src_q[OpW-2:0], 1'b0};
        end
        default: begin
          busy_d = 1'b0;
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    rem_q  <= rem_d;
    res_q  <= res_d;
    src_q  <= src_d;
    opb_q  <= opb_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ----- rtl/running_baseline_anomaly_check.sv -----
// ----------------------------------------------------------------------------
// running_baseline_anomaly_check
// Welford running statistics over history samples with a fixed-limit and
// mean + z * stddev anomaly check.
// ----------------------------------------------------------------------------
// Usage: beats arrive on the s_axis channel; tuser holds the operation
// (clear, add sample, check). Clear and add give no output beat; a check
// gives one beat on m_axis with the anomaly flags, limit, mean, stddev and
// count. Configuration (baseline_on, min_samples, z_gain) is written through
// cfg_we_i / cfg_idx_i / cfg_data_i. The user must write it only while the
// block is idle; the block itself does not enforce this. Clear completes on
// accept. Add runs a 64-step divide of the deviation by the count, then a
// 64-step multiply for M2. A check runs a 64-step divide of M2 by count-1, a
// 32-step square root, one z multiply and one compare; with fewer than two
// samples it skips the divide and the square root.
// The divides, square root and M2 multiply run on one shared iterative unit,
// so s_axis_tready is low while an item is in work.
// Reset clears the statistics and loads the default configuration.
// A check result sits in the output register; if the receiver stalls the
// next item is still taken, and a following check holds at its last step
// until the output register is free.
// ----------------------------------------------------------------------------
module running_baseline_anomaly_check
  import rbac_pkg::*;
#(
  parameter int unsigned COUNT_BITS = CountBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // sample[31:0], fixed_limit[63:32], history_ok[64], zero fill
  input  logic [InDataW-1:0]  s_axis_tdata,
  // operation[1:0]
  input  logic [1:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // anomaly[0], baseline_only[1], baseline_limit[33:2], mean_out[65:34],
  // std_dev[96:66], sample_count[112:97], zero fill
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_data_i
);

  localparam int unsigned CntExtW = COUNT_BITS + OutCntW;
  localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

  // state and configuration
  state_e                  state_q, state_d;
  logic                    bl_on_q;
  logic [CfgW-1:0]         min_q, zg_q;
  logic [COUNT_BITS-1:0]   count_q, count_d;
  logic signed [MeanW-1:0] mean_q, mean_d;
  logic [M2W-1:0]          m2_q, m2_d;

  // per-item working registers
  logic signed [DataW-1:0] val_q, val_d;
  logic signed [DataW-1:0] lim_q, lim_d;
  logic                    hist_q, hist_d;
  logic signed [MeanW:0]   dev_q, dev_d;
  logic [StdW-1:0]         sd_q, sd_d;
  logic [CfgW+StdW-1:0]    prod_q, prod_d;

  // output register
  logic                    ovld_q, ovld_d;
  logic [OutDataW-1:0]     odat_q, odat_d;

  // iterative unit
  iter_req_t               req;
  logic [OpW-1:0]          opa, opb;
  logic                    it_done;
  logic [2*OpW-1:0]        it_res;

  rbac_iter u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .opa_i  (opa),
    .opb_i  (opb),
    .done_o (it_done),
    .res_o  (it_res)
  );

  // input fields
  op_e                     in_op;
  logic signed [DataW-1:0] in_val;
  logic signed [DataW-1:0] in_lim;
  logic                    in_hist;
  logic                    in_fire;

  assign in_op   = op_e'(s_axis_tuser);
  assign in_val  = s_axis_tdata[DataW-1:0];
  assign in_lim  = s_axis_tdata[2*DataW-1:DataW];
  assign in_hist = s_axis_tdata[2*DataW];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // helpers for the datapath
  logic signed [MeanW-1:0] x_in;
  logic signed [MeanW-1:0] x_val;
  logic signed [MeanW:0]   quot;
  logic signed [MeanW+1:0] mnew_w;
  logic signed [MeanW-1:0] mnew;
  logic signed [MeanW:0]   dev2;
  logic [MeanW:0]          dev_mag, dev2_mag;
  logic [M2W:0]            m2_sum;
  logic [CntExtW-1:0]      cnt_ext, min_ext;
  logic [OutCntW-1:0]      cnt_out;
  logic signed [DataW-1:0] mean32;
  logic signed [DataW+9:0] blim_w;
  logic signed [DataW-1:0] blim;
  logic                    use_bl, limit_hit, base_hit;

  always_comb begin
    x_in     = {in_val, {GuardW{1'b0}}};
    x_val    = {val_q, {GuardW{1'b0}}};
    dev_mag  = dev_q[MeanW] ? (MeanW+1)'(-dev_q) : dev_q;
    quot     = dev_q[MeanW] ? -$signed(it_res[MeanW:0]) : $signed(it_res[MeanW:0]);
    mnew_w   = (MeanW+2)'(mean_q) + (MeanW+2)'(quot);
    mnew     = mnew_w[MeanW-1:0];
    dev2     = (MeanW+1)'(x_val) - (MeanW+1)'(mnew);
    dev2_mag = dev2[MeanW] ? (MeanW+1)'(-dev2) : dev2;
    m2_sum   = {1'b0, m2_q} + {1'b0, it_res[M2W+31:32]};
    cnt_ext  = CntExtW'(count_q);
    min_ext  = CntExtW'(min_q);
    cnt_out  = (cnt_ext > CntExtW'({OutCntW{1'b1}})) ? {OutCntW{1'b1}} : cnt_ext[OutCntW-1:0];
    mean32   = mean_q[MeanW-1:GuardW];
    blim_w   = (DataW+10)'(mean32) + (DataW+10)'({1'b0, prod_q[CfgW+StdW-1:8]});
    use_bl   = bl_on_q && hist_q && (cnt_ext >= min_ext) && (sd_q != '0);
    blim     = '0;
    if (use_bl) begin
      blim = (blim_w > (DataW+10)'(32'sh7FFFFFFF)) ? 32'sh7FFFFFFF : blim_w[DataW-1:0];
    end
    limit_hit = val_q > lim_q;
    base_hit  = use_bl && (val_q > blim);
  end

  // sequencer
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    mean_d   = mean_q;
    m2_d     = m2_q;
    val_d    = val_q;
    lim_d    = lim_q;
    hist_d   = hist_q;
    dev_d    = dev_q;
    sd_d     = sd_q;
    prod_d   = prod_q;
    ovld_d   = ovld_q && !m_axis_tready;
    odat_d   = odat_q;
    req      = '{start: 1'b0, mode: MODE_DIV};
    opa      = '0;
    opb      = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          val_d  = in_val;
          lim_d  = in_lim;
          hist_d = in_hist;
          case (in_op)
            OP_CLEAR: begin
              count_d = '0;
              mean_d  = '0;
              m2_d    = '0;
            end
            OP_ADD: begin
              if (count_q != CountMax) begin
                count_d = count_q + 1'b1;
                dev_d   = (MeanW+1)'(x_in) - (MeanW+1)'(mean_q);
                opa     = OpW'(((MeanW+1)'(x_in) - (MeanW+1)'(mean_q)) < 0 ?
                          (MeanW+1)'(-((MeanW+1)'(x_in) - (MeanW+1)'(mean_q))) :
                          ((MeanW+1)'(x_in) - (MeanW+1)'(mean_q)));
                opb     = OpW'(count_d);
                req     = '{start: 1'b1, mode: MODE_DIV};
                state_d = ST_ADD_DIV;
              end
            end
            OP_CHECK: begin
              if (count_q < COUNT_BITS'(2)) begin
                sd_d    = '0;
                state_d = ST_CHK_MUL;
              end else begin
                opa     = m2_q;
                opb     = OpW'(count_q - 1'b1);
                req     = '{start: 1'b1, mode: MODE_DIV};
                state_d = ST_CHK_DIV;
              end
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_ADD_DIV: begin
        if (it_done) begin
          mean_d  = mnew;
          opa     = OpW'(dev_mag);
          opb     = OpW'(dev2_mag);
          req     = '{start: 1'b1, mode: MODE_MUL};
          state_d = ST_ADD_MUL;
        end
      end
      ST_ADD_MUL: begin
        if (it_done) begin
          m2_d    = m2_sum[M2W] ? {M2W{1'b1}} : m2_sum[M2W-1:0];
          state_d = ST_IDLE;
        end
      end
      ST_CHK_DIV: begin
        if (it_done) begin
          opa     = it_res[OpW-1:0];
          req     = '{start: 1'b1, mode: MODE_SQRT};
          state_d = ST_CHK_SQRT;
        end
      end
      ST_CHK_SQRT: begin
        if (it_done) begin
          sd_d    = it_res[StdW] ? {StdW{1'b1}} : it_res[StdW-1:0];
          state_d = ST_CHK_MUL;
        end
      end
      ST_CHK_MUL: begin
        prod_d  = zg_q * sd_q;
        state_d = ST_CHK_FIN;
      end
      ST_CHK_FIN: begin
        if (!ovld_q || m_axis_tready) begin
          ovld_d  = 1'b1;
          odat_d  = OutDataW'({cnt_out, sd_q, mean32, blim,
                               base_hit && !limit_hit, limit_hit || base_hit});
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control and statistics registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      mean_q  <= '0;
      m2_q    <= '0;
      ovld_q  <= 1'b0;
      bl_on_q <= 1'b1;
      min_q   <= CfgW'(10);
      zg_q    <= CfgW'(768);
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      mean_q  <= mean_d;
      m2_q    <= m2_d;
      ovld_q  <= ovld_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_BASELINE_ON: bl_on_q <= cfg_data_i[0];
          CFG_MIN_SAMPLES: min_q   <= cfg_data_i;
          CFG_Z_GAIN:      zg_q    <= cfg_data_i;
          default:         bl_on_q <= bl_on_q;
        endcase
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    lim_q  <= lim_d;
    hist_q <= hist_d;
    dev_q  <= dev_d;
    sd_q   <= sd_d;
    prod_q <= prod_d;
    odat_q <= odat_d;
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = odat_q;

endmodule

// ----- sim/running_baseline_anomaly_check_tb.sv -----
// ----------------------------------------------------------------------------
// running_baseline_anomaly_check_tb
// Streams clear, add-sample, check and unused-op beats into the block and
// tracks the Welford count, mean and M2 alongside it. Every check beat gets
// an expected anomaly verdict that is compared field by field with the output
// beat. Configuration changes between phases while the block is idle; idling on
// both sides and one long output hold-off vary the handshake timing.
// ----------------------------------------------------------------------------
module running_baseline_anomaly_check_tb;
  import rbac_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DrainCycles = 200;
  localparam longint unsigned CycleLimit = 3000000;

  typedef struct {
    op_e         op;
    logic [31:0] sample;
    logic [31:0] fixed_limit;
    logic        history_ok;
  } beat_t;

  typedef struct packed {
    logic        anomaly;
    logic        baseline_only;
    logic [31:0] blimit;
    logic [31:0] mean;
    logic [30:0] sdev;
    logic [15:0] count;
  } verdict_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic [1:0]          s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we_i = 1'b0;
  logic [1:0]          cfg_idx_i = '0;
  logic [CfgW-1:0]     cfg_data_i = '0;

  running_baseline_anomaly_check u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  // shadow configuration and statistics
  logic               shadow_baseline_on = 1'b1;
  logic [15:0]        shadow_min_samples = 16'd10;
  logic [15:0]        shadow_z_gain = 16'd768;
  logic [15:0]        hist_count = '0;
  longint             hist_mean = 0;
  longint unsigned    hist_m2 = 0;

  beat_t    pending_beats[$];
  verdict_t verdicts_due[$];
  beat_t    beat_in_flight;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  bit       hold_off = 1'b0;
  int       mismatches = 0;
  longint unsigned cycle_cnt = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic longint unsigned isqrt64(longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // fold one sample into the running statistics
  task automatic fold_sample(logic [31:0] raw);
    longint x, d, d2, mnew;
    longint unsigned ad, ad2, inc;
    logic [127:0] prod;
    if (hist_count == 16'hFFFF) return;
    hist_count = hist_count + 1'b1;
    x = longint'($signed(raw)) * 65536;
    d = x - hist_mean;
    mnew = hist_mean + d / longint'(hist_count);
    d2 = x - mnew;
    ad = (d < 0) ? -d : d;
    ad2 = (d2 < 0) ? -d2 : d2;
    prod = {64'd0, ad} * {64'd0, ad2};
    prod = prod >> 32;
    inc = (prod[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : prod[63:0];
    hist_m2 = (hist_m2 > ~inc) ? 64'hFFFF_FFFF_FFFF_FFFF : hist_m2 + inc;
    hist_mean = mnew;
  endtask

  // anomaly verdict for one check beat
  function automatic verdict_t judge_value(beat_t b);
    verdict_t v;
    longint mean32, val, blim;
    longint unsigned sd;
    logic limit_hit, base_hit;
    mean32 = hist_mean >>> 16;
    if (hist_count < 2) sd = 0;
    else sd = isqrt64(hist_m2 / (hist_count - 1));
    if (sd > 64'h7FFF_FFFF) sd = 64'h7FFF_FFFF;
    val = $signed(b.sample);
    limit_hit = val > longint'($signed(b.fixed_limit));
    base_hit = 1'b0;
    blim = 0;
    if (shadow_baseline_on && b.history_ok && hist_count >= shadow_min_samples && sd > 0) begin
      blim = mean32 + longint'((64'(shadow_z_gain) * sd) >> 8);
      if (blim > 64'sh7FFF_FFFF) blim = 64'sh7FFF_FFFF;
      base_hit = val > blim;
    end
    v.anomaly = limit_hit | base_hit;
    v.baseline_only = base_hit & ~limit_hit;
    v.blimit = blim[31:0];
    v.mean = mean32[31:0];
    v.sdev = sd[30:0];
    v.count = hist_count;
    return v;
  endfunction

  // advance the shadow statistics on an accepted beat
  task automatic apply_beat(beat_t b);
    case (b.op)
      OP_CLEAR: begin
        hist_count = '0;
        hist_mean = 0;
        hist_m2 = 0;
      end
      OP_ADD: fold_sample(b.sample);
      OP_CHECK: verdicts_due.push_back(judge_value(b));
      default: ;
    endcase
  endtask

  // input driver: one beat in flight, refilled from the pending queue
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) apply_beat(beat_in_flight);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          beat_in_flight = pending_beats.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= beat_in_flight.op;
          s_axis_tdata <= {7'd0, beat_in_flight.history_ok, beat_in_flight.fixed_limit,
                           beat_in_flight.sample};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // output monitor and ready pattern
  always @(posedge clk_i) begin
    verdict_t want, got;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.anomaly = m_axis_tdata[0];
        got.baseline_only = m_axis_tdata[1];
        got.blimit = m_axis_tdata[33:2];
        got.mean = m_axis_tdata[65:34];
        got.sdev = m_axis_tdata[96:66];
        got.count = m_axis_tdata[112:97];
        if (verdicts_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected output beat %h", m_axis_tdata);
        end else begin
          want = verdicts_due.pop_front();
          if (got != want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp anom %0b only %0b lim %h mean %h sd %h cnt %0d / got anom %0b only %0b lim %h mean %h sd %h cnt %0d",
                       want.anomaly, want.baseline_only, want.blimit, want.mean, want.sdev,
                       want.count, got.anomaly, got.baseline_only, got.blimit, got.mean,
                       got.sdev, got.count);
          end
        end
      end
      m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("running_baseline_anomaly_check_tb failed");
      $finish;
    end
  end

  task automatic queue_beat(op_e op, logic [31:0] s, logic [31:0] lim, logic ok);
    beat_t b;
    b.op = op;
    b.sample = s;
    b.fixed_limit = lim;
    b.history_ok = ok;
    pending_beats.push_back(b);
  endtask

  function automatic logic [31:0] pick_sample(logic [31:0] center);
    case ($urandom_range(9))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return center + $urandom_range(32'h0004_0000) - 32'h0002_0000;
    endcase
  endfunction

  // mostly add/check runs around a drifting center, some clears and noise
  task automatic queue_random(int n);
    logic [31:0] center, s, lim;
    int r;
    center = $urandom;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      s = pick_sample(center);
      if (r < 3) begin
        queue_beat(OP_CLEAR, $urandom, $urandom, 1'($urandom_range(1)));
        center = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h00FF_FFFF);
      end else if (r < 5) begin
        queue_beat(OP_NONE, $urandom, $urandom, 1'($urandom_range(1)));
      end else if (r < 60) begin
        queue_beat(OP_ADD, s, $urandom, 1'($urandom_range(1)));
      end else begin
        lim = ($urandom_range(3) == 0) ? $urandom : s + $urandom_range(32'h0008_0000)
              - 32'h0004_0000;
        queue_beat(OP_CHECK, s, lim, $urandom_range(4) != 0);
      end
    end
  endtask

  // write one register; callers drain the block first
  task automatic write_reg(logic [1:0] idx, logic [15:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_BASELINE_ON: shadow_baseline_on = value[0];
      CFG_MIN_SAMPLES: shadow_min_samples = value;
      CFG_Z_GAIN:      shadow_z_gain = value;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_beats.size() != 0 || s_axis_tvalid || verdicts_due.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_idle(int mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
      default: begin send_idle_pct = 24; recv_stall_pct = 24; end
    endcase
  endtask

  // stimulus sequence
  initial begin
    logic [15:0] cfg_sets[6][3];
    cfg_sets = '{'{16'd1, 16'd10, 16'd768}, '{16'd1, 16'd0, 16'd0},
                 '{16'd1, 16'd65535, 16'd65535}, '{16'd0, 16'd2, 16'd768},
                 '{16'd1, 16'd2, 16'd65535}, '{16'd1, 16'd1, 16'd256}};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty history, unused op, extremes and saturation of m2
    queue_beat(OP_CHECK, 32'h0000_0000, 32'h0000_0000, 1'b1);
    queue_beat(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    queue_beat(OP_ADD, 32'h0001_0000, 32'h0, 1'b0);
    queue_beat(OP_CHECK, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    queue_beat(OP_CHECK, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    for (int i = 0; i < 6; i++) begin
      queue_beat(OP_ADD, 32'h8000_0000, 32'h0, 1'b1);
      queue_beat(OP_ADD, 32'h7FFF_FFFF, 32'h0, 1'b1);
    end
    queue_beat(OP_CHECK, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    queue_beat(OP_CHECK, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 1'b0);
    queue_beat(OP_CLEAR, 32'h0, 32'h0, 1'b0);
    for (int i = 0; i < 10; i++) queue_beat(OP_ADD, 32'h0001_0000 + i * 32'h100, 32'h0, 1'b1);
    queue_beat(OP_CHECK, 32'h0002_0000, 32'h0010_0000, 1'b1);
    queue_beat(OP_CHECK, 32'h0000_1000, 32'h8000_0000, 1'b1);
    drain();

    for (int p = 0; p < 6; p++) begin
      for (int r = 0; r < 3; r++) write_reg(r[1:0], cfg_sets[p][r]);
      set_idle(p);
      queue_random(245);
      if (p == 2) begin
        // long output hold-off while inputs keep coming
        hold_off = 1'b1;
        repeat (3000) @(posedge clk_i);
        hold_off = 1'b0;
      end
      drain();
    end

    if (mismatches == 0 && verdicts_due.size() == 0) begin
      $display("running_baseline_anomaly_check_tb passed");
    end else begin
      $display("running_baseline_anomaly_check_tb failed");
    end
    $finish;
  end

endmodule
